// ===== hdl/srg_pkg.sv =====
package srg_pkg;

   localparam int HEIGHT_DEF      = 128;
   localparam int WIDTH_DEF       = 128;
   localparam int MAX_REGIONS_DEF = 15;
   localparam int VALUE_BITS_DEF  = 16;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] CSR_GROW_FRACTION = 2'd0;
   localparam logic [1:0] CSR_MIN_PEAK      = 2'd1;
   localparam logic [1:0] CSR_MAX_REGIONS   = 2'd2;

   localparam logic [16:0] GROW_FRACTION_RST = 17'd32768;
   localparam logic [15:0] MIN_PEAK_RST      = 16'd3277;
   localparam logic [3:0]  MAX_REGIONS_RST   = 4'd5;

   // pixel status codes
   localparam logic [1:0] ST_USED = 2'd0;
   localparam logic [1:0] ST_FREE = 2'd1;
   localparam logic [1:0] ST_CUR  = 2'd2;

   // neighbour offset codes
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  row;
      logic [6:0]  col;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0] label;
      logic [3:0] region_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SEARCH,
      S_SRCH_WAIT,
      S_SRCH_END,
      S_SEED,
      S_POP,
      S_POP_WAIT,
      S_NB,
      S_NB_EVAL,
      S_FIN,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load_px;
      logic read_lbl;
      logic run_start;
      logic clr_step;
      logic srch_step;
      logic seed;
      logic pop_issue;
      logic pop_load;
      logic nb_issue;
      logic nb_skip;
      logic nb_eval;
      logic fin_start;
      logic fin_step;
      logic done_rsp;
   } cmd_type;

   typedef struct packed {
      logic rd_pend;
      logic rsp_busy;
      logic sweep_last;
      logic found;
      logic pop_exit;
      logic nb_inb;
      logic nb_last;
      logic fin_done;
      logic stop;
   } stat_type;

   // neighbour order: row offset -1..1, then column offset -1..1, centre skipped
   function automatic logic [1:0] nb_row_off(input logic [2:0] k);
      logic [1:0] off;
      unique case (k)
         3'd0, 3'd1, 3'd2: off = OFF_MINUS;
         3'd3, 3'd4:       off = OFF_ZERO;
         default:          off = OFF_PLUS;
      endcase
      return off;
   endfunction

   function automatic logic [1:0] nb_col_off(input logic [2:0] k);
      logic [1:0] off;
      unique case (k)
         3'd0, 3'd3, 3'd5: off = OFF_MINUS;
         3'd1, 3'd6:       off = OFF_ZERO;
         default:          off = OFF_PLUS;
      endcase
      return off;
   endfunction

endpackage

// ===== hdl/srg_ram.sv =====
module srg_ram #(
   parameter int DATA_BITS = srg_pkg::VALUE_BITS_DEF,
   parameter int DEPTH     = srg_pkg::HEIGHT_DEF * srg_pkg::WIDTH_DEF,
   localparam int AW       = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/srg_ctrl.sv =====
module srg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_op,
   output logic             req_stall,
   input  srg_pkg::stat_type stat,
   output srg_pkg::cmd_type  cmd
);
   import srg_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE) ||
                      ((req_op == OP_READ) && (stat.rd_pend || stat.rsp_busy));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (accept && req_op == OP_RUN) state_in = S_CLEAR;
         S_CLEAR:     if (stat.sweep_last) state_in = S_SEARCH;
         S_SEARCH:    if (stat.sweep_last) state_in = S_SRCH_WAIT;
         S_SRCH_WAIT: state_in = S_SRCH_END;
         S_SRCH_END:  state_in = stat.found ? S_SEED : S_DONE;
         S_SEED:      state_in = S_POP;
         S_POP:       state_in = stat.pop_exit ? S_FIN : S_POP_WAIT;
         S_POP_WAIT:  state_in = S_NB;
         S_NB: begin
            if (stat.nb_inb) begin
               state_in = S_NB_EVAL;
            end else if (stat.nb_last) begin
               state_in = S_POP;
            end
         end
         S_NB_EVAL:   state_in = stat.nb_last ? S_POP : S_NB;
         S_FIN:       if (stat.fin_done) state_in = S_CHECK;
         S_CHECK:     state_in = stat.stop ? S_DONE : S_SEARCH;
         S_DONE:      if (!stat.rsp_busy) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_px   = accept && (req_op == OP_LOAD);
            cmd.read_lbl  = accept && (req_op == OP_READ);
            cmd.run_start = accept && (req_op == OP_RUN);
         end
         S_CLEAR:  cmd.clr_step  = 1'b1;
         S_SEARCH: cmd.srch_step = 1'b1;
         S_SEED:   cmd.seed      = 1'b1;
         S_POP: begin
            cmd.fin_start = stat.pop_exit;
            cmd.pop_issue = !stat.pop_exit;
         end
         S_POP_WAIT: cmd.pop_load = 1'b1;
         S_NB: begin
            cmd.nb_issue = stat.nb_inb;
            cmd.nb_skip  = !stat.nb_inb;
         end
         S_NB_EVAL: cmd.nb_eval  = 1'b1;
         S_FIN:     cmd.fin_step = 1'b1;
         S_DONE:    cmd.done_rsp = !stat.rsp_busy;
         default:   cmd = '0;
      endcase
   end

endmodule

// ===== hdl/srg_dp.sv =====
module srg_dp #(
   parameter int HEIGHT      = srg_pkg::HEIGHT_DEF,
   parameter int WIDTH       = srg_pkg::WIDTH_DEF,
   parameter int MAX_REGIONS = srg_pkg::MAX_REGIONS_DEF,
   parameter int VALUE_BITS  = srg_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  srg_pkg::req_type  req_data,
   input  srg_pkg::cmd_type  cmd,
   output srg_pkg::stat_type stat,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [16:0]       csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output srg_pkg::rsp_type  rsp_data
);
   import srg_pkg::*;

   localparam int NPIX = HEIGHT * WIDTH;
   localparam int IDXW = $clog2(NPIX);
   localparam int CNTW = $clog2(NPIX + 1);
   localparam int RW   = $clog2(HEIGHT);
   localparam int CW   = $clog2(WIDTH);
   localparam int QW   = RW + CW;
   localparam int ACCW = $clog2(MAX_REGIONS + 1);
   localparam int THRW = VALUE_BITS + 17;

   function automatic logic [IDXW-1:0] idx_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
      return IDXW'(IDXW'(r) * IDXW'(WIDTH) + IDXW'(c));
   endfunction

   // configuration
   logic [16:0] grow_fraction_ff;
   logic [15:0] min_peak_ff;
   logic [3:0]  max_regions_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_fraction_ff <= GROW_FRACTION_RST;
         min_peak_ff      <= MIN_PEAK_RST;
         max_regions_ff   <= MAX_REGIONS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GROW_FRACTION: grow_fraction_ff <= csr_wdata;
            CSR_MIN_PEAK:      min_peak_ff      <= csr_wdata[15:0];
            CSR_MAX_REGIONS:   max_regions_ff   <= csr_wdata[3:0];
            default:           ;
         endcase
      end
   end

   // request decode
   logic            req_inside;
   logic [IDXW-1:0] req_idx;

   assign req_inside = (32'(req_data.row) < 32'(HEIGHT)) && (32'(req_data.col) < 32'(WIDTH));
   assign req_idx    = idx_of(RW'(req_data.row), CW'(req_data.col));

   // memory ports
   logic                  px_we, st_we, lb_we, q_we;
   logic [IDXW-1:0]       px_wa, px_ra, st_wa, st_ra, lb_wa, q_wa, q_ra;
   logic [VALUE_BITS-1:0] px_wd, px_rd;
   logic [1:0]            st_wd, st_rd;
   logic [3:0]            lb_wd, lb_rd;
   logic [QW-1:0]         q_wd, q_rd;

   // registers
   logic [IDXW-1:0]       sweep_ff, sd_idx_ff, seed_idx_ff, nidx_ff;
   logic [RW-1:0]         srow_ff, sd_r_ff, seed_r_ff, cur_r_ff, nr_ff;
   logic [CW-1:0]         scol_ff, sd_c_ff, seed_c_ff, cur_c_ff, nc_ff;
   logic                  srch_vld_ff, found_ff, clean_ff, more_ff, fin_vld_ff;
   logic [VALUE_BITS-1:0] peak_ff;
   logic [THRW-1:0]       thr_ff;
   logic [CNTW-1:0]       head_ff, tail_ff, fin_i_ff;
   logic [2:0]            nb_ff;
   logic [ACCW-1:0]       acc_ff;
   logic                  rd_pend_ff, rd_inside_ff, ever_run_ff, rsp_valid_ff;
   rsp_type               rsp_ff;

   // neighbour address
   logic [1:0]      roff, coff;
   logic            r_ok, c_ok, nb_inb, nb_last;
   logic [RW-1:0]   nr;
   logic [CW-1:0]   nc;
   logic [IDXW-1:0] n_idx;

   always_comb begin
      roff = nb_row_off(nb_ff);
      coff = nb_col_off(nb_ff);
      unique case (roff)
         OFF_MINUS: begin
            r_ok = cur_r_ff != '0;
            nr   = cur_r_ff - 1'b1;
         end
         OFF_PLUS: begin
            r_ok = cur_r_ff != RW'(HEIGHT - 1);
            nr   = cur_r_ff + 1'b1;
         end
         default: begin
            r_ok = 1'b1;
            nr   = cur_r_ff;
         end
      endcase
      unique case (coff)
         OFF_MINUS: begin
            c_ok = cur_c_ff != '0;
            nc   = cur_c_ff - 1'b1;
         end
         OFF_PLUS: begin
            c_ok = cur_c_ff != CW'(WIDTH - 1);
            nc   = cur_c_ff + 1'b1;
         end
         default: begin
            c_ok = 1'b1;
            nc   = cur_c_ff;
         end
      endcase
   end

   assign nb_inb  = r_ok && c_ok;
   assign nb_last = nb_ff == 3'd7;
   assign n_idx   = idx_of(nr, nc);

   logic            sweep_last, joins, push, fin_issue;
   logic [IDXW-1:0] fidx;

   assign sweep_last = sweep_ff == IDXW'(NPIX - 1);
   assign joins      = THRW'({px_rd, 16'h0000}) >= thr_ff;
   assign push       = cmd.nb_eval && (st_rd == ST_FREE) && joins && (32'(tail_ff) < NPIX);
   assign fin_issue  = cmd.fin_step && (fin_i_ff != tail_ff);
   assign fidx       = idx_of(q_rd[QW-1:CW], q_rd[CW-1:0]);

   // sweep over the map for clearing and seed search
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         srow_ff  <= '0;
         scol_ff  <= '0;
      end else if (cmd.clr_step || cmd.srch_step) begin
         if (sweep_last) begin
            sweep_ff <= '0;
            srow_ff  <= '0;
            scol_ff  <= '0;
         end else begin
            sweep_ff <= sweep_ff + 1'b1;
            if (scol_ff == CW'(WIDTH - 1)) begin
               scol_ff <= '0;
               srow_ff <= srow_ff + 1'b1;
            end else begin
               scol_ff <= scol_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sd_idx_ff <= sweep_ff;
      sd_r_ff   <= srow_ff;
      sd_c_ff   <= scol_ff;
   end

   // seed search: strict compare keeps the first of equal peaks
   always_ff @(posedge clock) begin
      if (reset) begin
         srch_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         srch_vld_ff <= cmd.srch_step;
         priority if (cmd.seed || cmd.run_start) begin
            found_ff <= 1'b0;
         end else if (srch_vld_ff && st_rd == ST_FREE && (!found_ff || px_rd > peak_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (srch_vld_ff && st_rd == ST_FREE && (!found_ff || px_rd > peak_ff)) begin
         peak_ff     <= px_rd;
         seed_idx_ff <= sd_idx_ff;
         seed_r_ff   <= sd_r_ff;
         seed_c_ff   <= sd_c_ff;
      end
      if (cmd.seed) begin
         thr_ff  <= THRW'(grow_fraction_ff) * THRW'(peak_ff);
         more_ff <= !(32'(peak_ff) < 32'(min_peak_ff));
      end
      if (cmd.pop_load) begin
         cur_r_ff <= q_rd[QW-1:CW];
         cur_c_ff <= q_rd[CW-1:0];
      end
      if (cmd.nb_issue) begin
         nidx_ff <= n_idx;
         nr_ff   <= nr;
         nc_ff   <= nc;
      end
   end

   // growth queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         clean_ff   <= 1'b0;
         nb_ff      <= '0;
         fin_i_ff   <= '0;
         fin_vld_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         fin_vld_ff <= fin_issue;
         if (cmd.run_start) begin
            acc_ff <= '0;
         end
         if (cmd.seed) begin
            head_ff  <= '0;
            tail_ff  <= CNTW'(1);
            clean_ff <= 1'b1;
         end
         if (cmd.pop_load) begin
            nb_ff <= '0;
         end
         if (cmd.nb_skip || cmd.nb_eval) begin
            nb_ff <= nb_ff + 1'b1;
            if (nb_last) begin
               head_ff <= head_ff + 1'b1;
            end
         end
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         // a used pixel that qualifies spoils the region
         if (cmd.nb_eval && st_rd != ST_FREE && st_rd != ST_CUR && joins) begin
            clean_ff <= 1'b0;
         end
         if (cmd.fin_start) begin
            fin_i_ff <= '0;
            if (clean_ff) begin
               acc_ff <= acc_ff + 1'b1;
            end
         end
         if (fin_issue) begin
            fin_i_ff <= fin_i_ff + 1'b1;
         end
      end
   end

   // memory port selection
   always_comb begin
      px_we = cmd.load_px && req_inside;
      px_wa = req_idx;
      px_wd = VALUE_BITS'(req_data.value);
      px_ra = cmd.nb_issue ? n_idx : sweep_ff;
      st_ra = cmd.nb_issue ? n_idx : sweep_ff;

      st_we = 1'b0;
      st_wa = sweep_ff;
      st_wd = ST_FREE;
      priority if (cmd.clr_step) begin
         st_we = 1'b1;
      end else if (cmd.seed) begin
         st_we = 1'b1;
         st_wa = seed_idx_ff;
         st_wd = ST_CUR;
      end else if (push || (cmd.nb_eval && st_rd == ST_FREE && joins)) begin
         st_we = 1'b1;
         st_wa = nidx_ff;
         st_wd = ST_CUR;
      end else if (fin_vld_ff) begin
         st_we = 1'b1;
         st_wa = fidx;
         st_wd = ST_USED;
      end

      lb_we = 1'b0;
      lb_wa = sweep_ff;
      lb_wd = '0;
      priority if (cmd.clr_step) begin
         lb_we = 1'b1;
      end else if (fin_vld_ff && clean_ff) begin
         lb_we = 1'b1;
         lb_wa = fidx;
         lb_wd = 4'(acc_ff);
      end

      q_we = cmd.seed || push;
      q_wa = cmd.seed ? '0 : tail_ff[IDXW-1:0];
      q_wd = cmd.seed ? {seed_r_ff, seed_c_ff} : {nr_ff, nc_ff};
      q_ra = cmd.pop_issue ? head_ff[IDXW-1:0] : fin_i_ff[IDXW-1:0];
   end

   srg_ram #(.DATA_BITS(VALUE_BITS), .DEPTH(NPIX)) u_pixel (
      .clock(clock), .wr_en(px_we), .wr_addr(px_wa), .wr_data(px_wd),
      .rd_addr(px_ra), .rd_data(px_rd)
   );

   srg_ram #(.DATA_BITS(2), .DEPTH(NPIX)) u_status (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );

   srg_ram #(.DATA_BITS(4), .DEPTH(NPIX)) u_label (
      .clock(clock), .wr_en(lb_we), .wr_addr(lb_wa), .wr_data(lb_wd),
      .rd_addr(req_idx), .rd_data(lb_rd)
   );

   srg_ram #(.DATA_BITS(QW), .DEPTH(NPIX)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         ever_run_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.read_lbl;
         if (cmd.run_start) begin
            ever_run_ff <= 1'b1;
         end
         if (rd_pend_ff || cmd.done_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_lbl) begin
         rd_inside_ff <= req_inside;
      end
      if (rd_pend_ff) begin
         // labels hold no meaning before the first run has cleared them
         rsp_ff.label        <= (rd_inside_ff && ever_run_ff) ? lb_rd : 4'd0;
         rsp_ff.region_count <= 4'(acc_ff);
      end else if (cmd.done_rsp) begin
         rsp_ff.label        <= 4'd0;
         rsp_ff.region_count <= 4'(acc_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      stat.rd_pend    = rd_pend_ff;
      stat.rsp_busy   = rsp_valid_ff && rsp_stall;
      stat.sweep_last = sweep_last;
      stat.found      = found_ff;
      stat.pop_exit   = (head_ff == tail_ff) || !clean_ff;
      stat.nb_inb     = nb_inb;
      stat.nb_last    = nb_last;
      stat.fin_done   = (fin_i_ff == tail_ff) && !fin_vld_ff;
      stat.stop       = !more_ff || (32'(acc_ff) >= 32'(max_regions_ff)) ||
                        (32'(acc_ff) >= MAX_REGIONS);
   end

`ifndef SYNTHESIS
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      32'(tail_ff) <= NPIX) else $error("queue overflow");
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(acc_ff) <= MAX_REGIONS) else $error("region count beyond limit");
   a_read_lands: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_valid_ff) else $error("label read lost");
`endif

endmodule

// ===== hdl/salient_region_growing_unit.sv =====
// Seeded 8-connected region growing over a HEIGHT x WIDTH saliency map held in
// single-port-write, registered-read memories. A pixel load (or an unused
// operation code) is taken every cycle while the unit is idle; a label read is
// not taken while an earlier read is pending or a held answer is stalled; its
// answer passes from the registered label-memory read into the output register.
// A run first clears the status and label memories, then for each region does a
// full seed-search sweep, a seed step, per popped pixel a queue read and a visit
// of each neighbour (skipped if off the map, else a status/pixel memory read and
// an evaluation), a step that finds the queue empty or the region spoilt, a final
// queue pass that labels a clean region and retires its pixels, and a stop check.
// During a run no transaction is taken; configuration writes should be made
// only while the unit is idle.
module salient_region_growing_unit #(
   parameter int HEIGHT      = srg_pkg::HEIGHT_DEF,
   parameter int WIDTH       = srg_pkg::WIDTH_DEF,
   parameter int MAX_REGIONS = srg_pkg::MAX_REGIONS_DEF,
   parameter int VALUE_BITS  = srg_pkg::VALUE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srg_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [16:0]      csr_wdata
);
   import srg_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   srg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   srg_dp #(
      .HEIGHT      (HEIGHT),
      .WIDTH       (WIDTH),
      .MAX_REGIONS (MAX_REGIONS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/salient_region_growing_unit_test.sv =====
`timescale 1ns / 100ps

module salient_region_growing_unit_test;
   import srg_pkg::*;

   localparam int ROWS   = 128;
   localparam int COLS   = 128;
   localparam int NPIX   = ROWS * COLS;
   localparam int REG_CAP = 15;
   localparam int STALL_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   salient_region_growing_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // mirror of the unit's state
   logic [15:0] map_px [NPIX];
   logic [1:0]  map_st [NPIX];
   logic [3:0]  map_lbl [NPIX];
   int          grow_q [NPIX];
   logic [3:0]  region_total = '0;
   logic [16:0] frac_cfg = GROW_FRACTION_RST;
   logic [15:0] peak_floor_cfg = MIN_PEAK_RST;
   logic [3:0]  region_cap_cfg = MAX_REGIONS_RST;

   rsp_type     answer_q [$];
   int          mismatches = 0;
   int          rsp_hold = 0;
   int          quiet_cycles = 0;
   bit          no_idle = 1'b0;

   function automatic bit pixel_joins(logic [15:0] v, logic [15:0] peak);
      return ({v, 16'd0} >= (48'(frac_cfg) * 48'(peak)));
   endfunction

   task automatic grow_regions();
      int i, lim, seed, head, tail, r, c, nr, nc, n, dr, dc;
      bit more, found, clean;
      logic [15:0] peak;
      for (i = 0; i < NPIX; i++) begin
         map_st[i] = ST_FREE;
         map_lbl[i] = '0;
      end
      region_total = '0;
      lim = (region_cap_cfg < REG_CAP) ? region_cap_cfg : REG_CAP;
      more = 1'b1;
      while (more) begin
         found = 1'b0;
         clean = 1'b1;
         seed = 0;
         peak = '0;
         head = 0;
         tail = 0;
         for (i = 0; i < NPIX; i++) begin
            if (map_st[i] == ST_FREE && (!found || map_px[i] > peak)) begin
               found = 1'b1;
               seed = i;
               peak = map_px[i];
            end
         end
         if (!found) break;
         if (peak < peak_floor_cfg) more = 1'b0;
         grow_q[tail++] = seed;
         map_st[seed] = ST_CUR;
         while (head < tail && clean) begin
            r = grow_q[head] / COLS;
            c = grow_q[head] % COLS;
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  nr = r + dr;
                  nc = c + dc;
                  if (dr == 0 && dc == 0) continue;
                  if (nr < 0 || nr >= ROWS || nc < 0 || nc >= COLS) continue;
                  n = nr * COLS + nc;
                  if (map_st[n] == ST_CUR) continue;
                  if (!pixel_joins(map_px[n], peak)) continue;
                  if (map_st[n] == ST_FREE) begin
                     if (tail < NPIX) grow_q[tail++] = n;
                     map_st[n] = ST_CUR;
                  end else begin
                     clean = 1'b0;
                  end
               end
            end
            head++;
         end
         if (clean) begin
            region_total++;
            for (i = 0; i < tail; i++) map_lbl[grow_q[i]] = region_total;
         end
         for (i = 0; i < tail; i++) map_st[grow_q[i]] = ST_USED;
         if (region_total >= lim) more = 1'b0;
      end
   endtask

   task automatic predict_answer(req_type t);
      rsp_type a;
      int idx;
      idx = int'(t.row) * COLS + int'(t.col);
      case (t.operation)
         OP_LOAD: map_px[idx] = t.value;
         OP_RUN: begin
            grow_regions();
            a.label = '0;
            a.region_count = region_total;
            answer_q.insert(answer_q.size(), a);
         end
         OP_READ: begin
            a.label = map_lbl[idx];
            a.region_count = region_total;
            answer_q.insert(answer_q.size(), a);
         end
         default: ;
      endcase
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_item(logic [1:0] op, logic [6:0] row, logic [6:0] col,
                            logic [15:0] value);
      int gap;
      req_type t;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      t.operation = op;
      t.row = row;
      t.col = col;
      t.value = value;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      predict_answer(t);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_GROW_FRACTION: frac_cfg = val;
         CSR_MIN_PEAK:      peak_floor_cfg = val[15:0];
         CSR_MAX_REGIONS:   region_cap_cfg = val[3:0];
         default: ;
      endcase
   endtask

   function automatic logic [15:0] map_value();
      // mostly low background with sparse high peaks keeps regions small
      if ($urandom_range(0, 99) < 3) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 16383));
   endfunction

   task automatic test_load_map();
      int r, c;
      no_idle = 1'b1;
      for (r = 0; r < ROWS; r++) begin
         if (r == 64) no_idle = 1'b0;
         for (c = 0; c < COLS; c++) begin
            if (r == 0 && c == 0)
               send_item(OP_LOAD, 7'(r), 7'(c), 16'd0);
            else if (r == ROWS - 1 && c == COLS - 1)
               send_item(OP_LOAD, 7'(r), 7'(c), 16'hFFFF);
            else if ((r == 20 && c == 30) || (r == 90 && c == 10))
               send_item(OP_LOAD, 7'(r), 7'(c), 16'hFFFF); // tie for the seed
            else
               send_item(OP_LOAD, 7'(r), 7'(c), map_value());
         end
      end
      wait_idle();
   endtask

   task automatic test_directed();
      send_item(2'd3, 7'd5, 7'd5, 16'hFFFF);          // unused code, no answer
      send_item(OP_READ, 7'd0, 7'd0, 16'd0);
      send_item(OP_READ, 7'd127, 7'd127, 16'd0);
      wait_idle();
      write_csr(CSR_GROW_FRACTION, 17'd45000);
      write_csr(CSR_MIN_PEAK, 17'd20000);
      write_csr(CSR_MAX_REGIONS, 17'd5);
      send_item(OP_RUN, 7'd0, 7'd0, 16'd0);
      send_item(OP_READ, 7'd127, 7'd127, 16'd0);
      send_item(OP_READ, 7'd20, 7'd30, 16'd0);
      send_item(OP_READ, 7'd90, 7'd10, 16'd0);
      send_item(OP_READ, 7'd0, 7'd127, 16'd0);
      send_item(OP_READ, 7'd127, 7'd0, 16'd0);
      send_item(OP_READ, 7'd0, 7'd0, 16'd0);
      wait_idle();
   endtask

   task automatic random_traffic(int count);
      int i, pick;
      for (i = 0; i < count; i++) begin
         no_idle = ((i / 60) % 4 == 3);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_item(OP_READ, 7'($urandom), 7'($urandom), 16'($urandom));
         else if (pick < 95)
            send_item(OP_LOAD, 7'($urandom), 7'($urandom), map_value());
         else
            send_item(2'd3, 7'($urandom), 7'($urandom), 16'($urandom));
      end
      wait_idle();
   endtask

   task automatic test_run_setting(logic [16:0] frac, logic [15:0] floor_val,
                                   logic [3:0] cap, int count);
      write_csr(CSR_GROW_FRACTION, frac);
      write_csr(CSR_MIN_PEAK, {1'b0, floor_val});
      write_csr(CSR_MAX_REGIONS, {13'd0, cap});
      send_item(OP_RUN, 7'($urandom), 7'($urandom), 16'($urandom));
      random_traffic(count);
   endtask

   initial begin
      // labels read as zero until the first run
      foreach (map_lbl[i]) map_lbl[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_load_map();
      test_directed();
      random_traffic(450);
      test_run_setting(17'd65536, 16'd0, 4'd15, 450);     // exact peak match only
      test_run_setting(17'd65536, 16'd0, 4'd1, 450);
      test_run_setting(17'd0, 16'hFFFF, 4'd0, 450);       // whole map joins
      repeat (20) @(negedge clock);
      if (mismatches == 0 && answer_q.size() == 0) begin
         $display("salient_region_growing_unit test passed");
      end else begin
         $display("salient_region_growing_unit test failed");
      end
      $finish;
   end

   // result stall pattern
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold <= no_idle ? 0 : $urandom_range(0, 8);
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: label %0d count %0d",
                        rsp_data.label, rsp_data.region_count);
         end else begin
            want = answer_q.pop_front();
            if (rsp_data.label !== want.label ||
                rsp_data.region_count !== want.region_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: label exp %0d got %0d, count exp %0d got %0d",
                           want.label, rsp_data.label, want.region_count,
                           rsp_data.region_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("salient_region_growing_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
